### sv/cpr_pkg.sv
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned NODES    = 1024;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned MAX_DIMS = 3;

  localparam logic [31:0] TIME_STEP_RST = 32'h0001_0000;
  localparam logic [1:0]  DIMS_RST      = 2'd3;

  // register index taken from paddr[2]
  localparam logic REG_TIME_STEP = 1'b0;
  localparam logic REG_DIMS      = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              in_contact;
    logic signed [31:0] pressure_x;
    logic signed [31:0] pressure_y;
    logic signed [31:0] pressure_z;
    logic [31:0]       time_scale;
  } cpr_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_echo;
    logic [31:0]       regularized_pressure;
  } cpr_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [31:0]       wr_data;
  } cpr_wr_t;

endpackage

### sv/cpr_store.sv
`timescale 1ns / 1ps

module cpr_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [cpr_pkg::NODE_W-1:0]   rd_addr_i,
  output logic [31:0]                  rd_data_o,
  input  cpr_pkg::cpr_wr_t             wr_i,
  output logic                         clr_busy_o
);
  import cpr_pkg::*;

  logic [31:0]     mem [NODES];
  logic [NODE_W:0] clr_q;

  assign clr_busy_o = ~clr_q[NODE_W];

  // sweep zeros through the array once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_q[NODE_W]) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_q[NODE_W]) begin
      mem[clr_q[NODE_W-1:0]] <= '0;
    end else if (wr_i.wr_en) begin
      mem[wr_i.wr_addr] <= wr_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

### sv/contact_pressure_regularizer.sv
`timescale 1ns / 1ps
// From accept to result strobe: a square per component (shift-add multiplier plus
//   accumulate), the root, then two low-pass products and the divider unless out of
//   contact or the time scale is zero.
// Throughput: one word at a time; busy is high after accept through the strobe cycle.
// Reset: control and config registers reset and a clearing pass zeroes the per-node store,
//   busy high meanwhile. valid_o is a one-cycle strobe; the receiver cannot stall.
module contact_pressure_regularizer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cpr_pkg::cpr_in_t     in_i,
  output logic                 valid_o,
  output cpr_pkg::cpr_out_t    out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cpr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MACC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_SQ = 2'd0;
  localparam logic [1:0] PH_P1 = 2'd1;
  localparam logic [1:0] PH_P2 = 2'd2;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (32'd0 - v) : v;
  endfunction

  logic [31:0] time_step_q;
  logic [1:0]  dims_q;

  logic [2:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  dim_q, dim_d;
  logic [1:0]  ndims_q, ndims_d;
  logic [6:0]  cnt_q, cnt_d;
  cpr_in_t     in_q, in_d;
  logic [31:0] mul_a_q, mul_a_d;
  logic [63:0] prod_q, prod_d;
  logic [64:0] acc_q, acc_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [32:0] den_q, den_d;
  logic [31:0] quo_q, quo_d;
  logic        sat_q, sat_d;
  logic [31:0] res_q, res_d;

  logic        accept;
  logic        clr_busy;
  logic [31:0] old_val;
  cpr_wr_t     wr;

  logic [32:0] mul_hi;
  logic [35:0] sq_r;
  logic [35:0] sq_t;
  logic [34:0] dv_r;
  logic [31:0] next_comp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIMS) ? {30'd0, dims_q} : time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      dims_q      <= DIMS_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIME_STEP) begin
        time_step_q <= pwdata;
      end else begin
        dims_q <= pwdata[1:0];
      end
    end
  end

  assign busy   = (state_q != S_IDLE) || clr_busy;
  assign accept = start && !busy;

  cpr_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (in_i.node_index),
    .rd_data_o  (old_val),
    .wr_i       (wr),
    .clr_busy_o (clr_busy)
  );

  assign wr.wr_en   = (state_q == S_OUT);
  assign wr.wr_addr = in_q.node_index;
  assign wr.wr_data = res_q;

  assign valid_o                    = (state_q == S_OUT);
  assign out_o.node_echo            = in_q.node_index;
  assign out_o.regularized_pressure = res_q;

  // shift-add step: add multiplicand into the high half, shift right one bit
  assign mul_hi = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, mul_a_q} : 33'd0);
  assign sq_r   = {rem_q, acc_q[63:62]};
  assign sq_t   = {2'b00, root_q, 2'b01};
  assign dv_r   = {rem_q, acc_q[64]};

  always_comb begin
    unique case (dim_q)
      2'd0:    next_comp = abs32(in_q.pressure_y);
      2'd1:    next_comp = abs32(in_q.pressure_z);
      default: next_comp = abs32(in_q.pressure_z);
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    dim_d   = dim_q;
    ndims_d = ndims_q;
    cnt_d   = cnt_q;
    in_d    = in_q;
    mul_a_d = mul_a_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    den_d   = den_q;
    quo_d   = quo_q;
    sat_d   = sat_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          in_d    = in_i;
          ndims_d = (dims_q == 2'd0) ? 2'd1 : dims_q;
          dim_d   = 2'd0;
          phase_d = PH_SQ;
          mul_a_d = abs32(in_i.pressure_x);
          prod_d  = {32'd0, abs32(in_i.pressure_x)};
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = {mul_hi, prod_q[31:1]};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'd31) begin
          state_d = S_MACC;
        end
      end
      S_MACC: begin
        acc_d = acc_q + {1'b0, prod_q};
        cnt_d = '0;
        priority if (phase_q == PH_SQ && (dim_q + 2'd1) < ndims_q) begin
          dim_d   = dim_q + 2'd1;
          mul_a_d = next_comp;
          prod_d  = {32'd0, next_comp};
          state_d = S_MUL;
        end else if (phase_q == PH_SQ) begin
          rem_d   = '0;
          root_d  = '0;
          state_d = S_SQRT;
        end else if (phase_q == PH_P1) begin
          phase_d = PH_P2;
          mul_a_d = time_step_q;
          prod_d  = {32'd0, root_q};
          state_d = S_MUL;
        end else begin
          rem_d   = '0;
          quo_d   = '0;
          sat_d   = 1'b0;
          den_d   = {1'b0, in_q.time_scale} + {1'b0, time_step_q};
          state_d = S_DIV;
        end
      end
      S_SQRT: begin
        acc_d = {acc_q[64], acc_q[61:0], 2'b00};
        cnt_d = cnt_q + 7'd1;
        if (sq_r >= sq_t) begin
          rem_d  = 34'(sq_r - sq_t);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = sq_r[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
        if (cnt_q == 7'd31) begin
          priority if (!in_q.in_contact) begin
            res_d   = '0;
            state_d = S_OUT;
          end else if (in_q.time_scale == 32'd0) begin
            res_d   = root_d;
            state_d = S_OUT;
          end else begin
            phase_d = PH_P1;
            mul_a_d = old_val;
            prod_d  = {32'd0, in_q.time_scale};
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_MUL;
          end
        end
      end
      S_DIV: begin
        acc_d = {acc_q[63:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        sat_d = sat_q | quo_q[31];
        if (dv_r >= {2'b00, den_q}) begin
          rem_d = 34'(dv_r - {2'b00, den_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = dv_r[33:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        if (cnt_q == 7'd64) begin
          res_d   = sat_d ? 32'hFFFF_FFFF : quo_d;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SQ;
      dim_q   <= '0;
      ndims_q <= 2'd1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      dim_q   <= dim_d;
      ndims_q <= ndims_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    mul_a_q <= mul_a_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    sat_q   <= sat_d;
    res_q   <= res_d;
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !valid_o)
    else $error("accepted word did not hold busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy)
    else $error("result strobe not followed by idle");

  a_no_clear_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> state_q == S_IDLE)
    else $error("sequencer ran during store clearing");

  a_dims_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> ndims_q != 2'd0 && dim_q < ndims_q)
    else $error("component counter out of range");

endmodule
